### sv/tts_pkg.sv
package tts_pkg;

   // Widths of the request, response and register fields.
   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int OFFSET_W = 11;
   localparam int CELL_W   = 16;
   localparam int COLOR_W  = 8;

   // Operation codes on the request channel.
   localparam logic [OP_W-1:0] OP_PUT_CHAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE  = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_CURSOR = 2'd2;
   localparam logic [OP_W-1:0] OP_READ_CELL  = 2'd3;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'h0a;
   localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'h20;
   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;
   localparam logic [CELL_W-1:0]  BLANK_RESET      = 16'h0720;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic [2:0] {
      KIND_PUT,
      KIND_NEWLINE,
      KIND_BACKSPACE,
      KIND_SET,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CHAR_W-1:0]   character;
      logic [COL_W-1:0]    column;
      logic [ROW_W-1:0]    row;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADDR,
      ST_EXEC,
      ST_SCROLL,
      ST_RESP
   } back_state_type;

endpackage

### sv/tts_if.sv
interface tts_req_if;
   logic                            valid;
   logic                            ready;
   logic [tts_pkg::OP_W-1:0]        operation;
   logic [tts_pkg::CHAR_W-1:0]      character;
   logic [tts_pkg::COL_W-1:0]       target_column;
   logic [tts_pkg::ROW_W-1:0]       target_row;

   modport source (output valid, operation, character, target_column, target_row,
                   input ready);
   modport sink (input valid, operation, character, target_column, target_row,
                 output ready);
endinterface

interface tts_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tts_pkg::COL_W-1:0]       cursor_column;
   logic [tts_pkg::ROW_W-1:0]       cursor_row;
   logic [tts_pkg::OFFSET_W-1:0]    cursor_offset;
   logic [tts_pkg::CELL_W-1:0]      cell_data;

   modport source (output valid, cursor_column, cursor_row, cursor_offset, cell_data,
                   input ready);
   modport sink (input valid, cursor_column, cursor_row, cursor_offset, cell_data,
                 output ready);
endinterface

interface tts_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tts_pkg::COLOR_W-1:0]     text_color;

   modport source (output valid, text_color, input ready);
   modport sink (input valid, text_color, output ready);
endinterface

### sv/tts_front.sv
module tts_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   tts_req_if.sink                   req,
   input  logic                      accepting,
   input  tts_pkg::queue_status_type queue_status,
   output logic                      push,
   output tts_pkg::cmd_type          push_cmd
);

   localparam int MAX_COL = COLUMNS - 1;
   localparam int MAX_ROW = ROWS - 1;

   assign req.ready = accepting && !queue_status.full;
   assign push      = req.valid && req.ready;

   always_comb begin
      push_cmd.character = req.character;
      // Targets are clamped here so the back end only sees legal positions.
      if (int'(req.target_column) > MAX_COL) begin
         push_cmd.column = tts_pkg::COL_W'(MAX_COL);
      end else begin
         push_cmd.column = req.target_column;
      end
      if (int'(req.target_row) > MAX_ROW) begin
         push_cmd.row = tts_pkg::ROW_W'(MAX_ROW);
      end else begin
         push_cmd.row = req.target_row;
      end
      case (req.operation)
         tts_pkg::OP_PUT_CHAR: begin
            if (req.character == tts_pkg::NEWLINE_CODE) begin
               push_cmd.kind = tts_pkg::KIND_NEWLINE;
            end else begin
               push_cmd.kind = tts_pkg::KIND_PUT;
            end
         end
         tts_pkg::OP_BACKSPACE:  push_cmd.kind = tts_pkg::KIND_BACKSPACE;
         tts_pkg::OP_SET_CURSOR: push_cmd.kind = tts_pkg::KIND_SET;
         tts_pkg::OP_READ_CELL:  push_cmd.kind = tts_pkg::KIND_READ;
         default:                push_cmd.kind = tts_pkg::KIND_READ;
      endcase
   end

endmodule

### sv/tts_queue.sv
module tts_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tts_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output tts_pkg::cmd_type          head_cmd,
   output tts_pkg::queue_status_type queue_status
);

   localparam int CNT_W = tts_pkg::QUEUE_PTR_W + 1;

   tts_pkg::cmd_type                   entries_ff [tts_pkg::QUEUE_DEPTH];
   logic [tts_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [tts_pkg::QUEUE_PTR_W-1:0]    wr_ptr_in;
   logic [tts_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [tts_pkg::QUEUE_PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;

   assign queue_status.full  = (count_ff == CNT_W'(tts_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head_cmd           = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/tts_back.sv
module tts_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tts_pkg::cmd_type               head_cmd,
   input  tts_pkg::queue_status_type      queue_status,
   input  logic [tts_pkg::COLOR_W-1:0]    text_color,
   output logic                           pop,
   output logic                           accepting,
   tts_rsp_if.source                      rsp
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CW         = $clog2(COLUMNS);
   localparam int RW         = $clog2(ROWS);
   localparam int AW         = $clog2(CELL_COUNT);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
   localparam logic [RW:0]   ROWS_EXT  = (RW + 1)'(ROWS);

   tts_pkg::back_state_type       state_ff;
   tts_pkg::back_state_type       state_in;
   tts_pkg::cmd_type              cmd_ff;
   tts_pkg::cmd_type              cmd_in;
   logic [CW-1:0]                 col_ff;
   logic [CW-1:0]                 col_in;
   logic [RW-1:0]                 row_ff;
   logic [RW-1:0]                 row_in;
   logic [RW-1:0]                 top_ff;
   logic [RW-1:0]                 top_in;
   logic [CW-1:0]                 sel_col_ff;
   logic [CW-1:0]                 sel_col_in;
   logic [RW-1:0]                 phys_row_ff;
   logic [RW-1:0]                 phys_row_in;
   logic [AW-1:0]                 addr_ff;
   logic [AW-1:0]                 addr_in;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic [RW-1:0]                 logical_row;
   logic [RW:0]                   row_sum;
   logic                          advance_row;

   logic                          wr_en;
   logic [tts_pkg::CELL_W-1:0]    wr_data;
   logic                          rd_en;
   logic [tts_pkg::CELL_W-1:0]    rd_data_ff;
   logic [tts_pkg::CELL_W-1:0]    cells_mem [CELL_COUNT];

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_load;
   logic [tts_pkg::COL_W-1:0]     rsp_col_ff;
   logic [tts_pkg::ROW_W-1:0]     rsp_row_ff;
   logic [tts_pkg::OFFSET_W-1:0]  rsp_offset_ff;
   logic [tts_pkg::CELL_W-1:0]    rsp_data_ff;

   assign accepting         = (state_ff != tts_pkg::ST_INIT);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.cursor_column = rsp_col_ff;
   assign rsp.cursor_row    = rsp_row_ff;
   assign rsp.cursor_offset = rsp_offset_ff;
   assign rsp.cell_data     = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      top_in       = top_ff;
      sel_col_in   = sel_col_ff;
      phys_row_in  = phys_row_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      logical_row  = row_ff;
      row_sum      = '0;
      advance_row  = 1'b0;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_data      = {text_color, tts_pkg::SPACE_CODE};
      rd_en        = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         tts_pkg::ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = tts_pkg::BLANK_RESET;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = tts_pkg::ST_IDLE;
            end
         end
         tts_pkg::ST_IDLE: begin
            if (!queue_status.empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               case (head_cmd.kind)
                  tts_pkg::KIND_BACKSPACE: sel_col_in = col_ff - 1'b1;
                  tts_pkg::KIND_READ: begin
                     sel_col_in  = CW'(head_cmd.column);
                     logical_row = RW'(head_cmd.row);
                  end
                  default: sel_col_in = col_ff;
               endcase
               // The screen is a ring of rows; top_ff is the physical top row.
               row_sum = {1'b0, logical_row} + {1'b0, top_ff};
               if (row_sum >= ROWS_EXT) begin
                  row_sum = row_sum - ROWS_EXT;
               end
               phys_row_in = row_sum[RW-1:0];
               state_in    = tts_pkg::ST_ADDR;
            end
         end
         tts_pkg::ST_ADDR: begin
            addr_in  = AW'(32'(phys_row_ff) * COLUMNS + 32'(sel_col_ff));
            state_in = tts_pkg::ST_EXEC;
         end
         tts_pkg::ST_EXEC: begin
            state_in = tts_pkg::ST_RESP;
            case (cmd_ff.kind)
               tts_pkg::KIND_PUT: begin
                  wr_en   = 1'b1;
                  wr_data = {text_color, cmd_ff.character};
                  if (col_ff == LAST_COL) begin
                     col_in      = '0;
                     advance_row = 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
               tts_pkg::KIND_NEWLINE: begin
                  col_in      = '0;
                  advance_row = 1'b1;
               end
               tts_pkg::KIND_BACKSPACE: begin
                  if (col_ff != '0) begin
                     wr_en  = 1'b1;
                     col_in = col_ff - 1'b1;
                  end
               end
               tts_pkg::KIND_SET: begin
                  col_in = CW'(cmd_ff.column);
                  row_in = RW'(cmd_ff.row);
               end
               tts_pkg::KIND_READ: rd_en = 1'b1;
               default: ;
            endcase
            if (advance_row) begin
               if (row_ff == LAST_ROW) begin
                  // Scrolling: the old top row becomes the new bottom row and is blanked.
                  addr_in  = AW'(32'(top_ff) * COLUMNS);
                  count_in = '0;
                  top_in   = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                  state_in = tts_pkg::ST_SCROLL;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         tts_pkg::ST_SCROLL: begin
            wr_en    = 1'b1;
            addr_in  = addr_ff + 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_COL) begin
               state_in = tts_pkg::ST_RESP;
            end
         end
         tts_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tts_pkg::ST_IDLE;
            end
         end
         default: state_in = tts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tts_pkg::ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sel_col_ff  <= sel_col_in;
      phys_row_ff <= phys_row_in;
      count_ff    <= count_in;
      if (rsp_load) begin
         rsp_col_ff    <= tts_pkg::COL_W'(col_ff);
         rsp_row_ff    <= tts_pkg::ROW_W'(row_ff);
         rsp_offset_ff <= tts_pkg::OFFSET_W'(32'(row_ff) * COLUMNS + 32'(col_ff));
         rsp_data_ff   <= (cmd_ff.kind == tts_pkg::KIND_READ) ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_mem[addr_ff];
      end
   end

   a_pop_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == tts_pkg::ST_IDLE) && !queue_status.empty)
      else $error("queue popped outside idle or while empty");

   a_scroll_moves_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tts_pkg::ST_EXEC) && (state_in == tts_pkg::ST_SCROLL)
      |=> top_ff != $past(top_ff))
      else $error("scroll did not advance the top row");

   a_no_write_in_idle_or_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tts_pkg::ST_IDLE) || (state_ff == tts_pkg::ST_RESP) |-> !wr_en)
      else $error("screen write outside an execute, scroll or clear state");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= LAST_ROW) && (col_ff <= LAST_COL) && (top_ff <= LAST_ROW))
      else $error("cursor or top row out of range");

endmodule

### sv/text_terminal_screen_writer.sv
// Channel  Direction  Handshake      Payload
// req_port in         valid / ready  operation, character, target_column, target_row
// rsp_port out        valid / ready  cursor_column, cursor_row, cursor_offset, cell_data
// csr_port in         valid / ready  text_color (ready is always high)
//
// A request steps through the back-end states pop, address multiply, execute, response load.
// A put character or newline that leaves the bottom row adds a pass that blanks one row
// on the screen memory's single write port.
// After reset the screen memory is cleared one cell a cycle over all COLUMNS*ROWS cells
// (2000 by default), and no request is accepted until that pass ends.
// A two-entry queue takes requests while the back end works or a response waits.
module text_terminal_screen_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tts_req_if.sink    req_port,
   tts_rsp_if.source  rsp_port,
   tts_csr_if.sink    csr_port
);

   logic [tts_pkg::COLOR_W-1:0]  text_color_ff;
   logic                         push;
   logic                         pop;
   logic                         accepting;
   tts_pkg::cmd_type             push_cmd;
   tts_pkg::cmd_type             head_cmd;
   tts_pkg::queue_status_type    queue_status;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= tts_pkg::TEXT_COLOR_RESET;
      end else if (csr_port.valid) begin
         text_color_ff <= csr_port.text_color;
      end
   end

   tts_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req          (req_port),
      .accepting    (accepting),
      .queue_status (queue_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   tts_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_cmd     (push_cmd),
      .pop          (pop),
      .head_cmd     (head_cmd),
      .queue_status (queue_status)
   );

   tts_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .queue_status (queue_status),
      .text_color   (text_color_ff),
      .pop          (pop),
      .accepting    (accepting),
      .rsp          (rsp_port)
   );

endmodule
